// ===== hw/rtl/rwls_pkg.sv =====
// Package for the line simplifier: item types, widths, command and status types, op tables.
`timescale 1ns / 1ps
`default_nettype none
package rwls_pkg;

    // Coordinate and derived widths
    localparam int COORD_BITS = 24;
    localparam int DIFF_BITS  = COORD_BITS + 1;          // vertex minus anchor, signed
    localparam int THR_BITS   = 24;
    localparam int THR2_BITS  = 2 * THR_BITS;
    localparam int LW         = 2 * COORD_BITS + 2;      // squared direction length
    localparam int XW         = 2 * COORD_BITS + 2;      // cross product component, signed
    localparam int AW         = (LW > THR2_BITS) ? LW : THR2_BITS;  // widest multiplicand
    localparam int HW         = (AW + 1) / 2;            // multiplier operand width
    localparam int PW         = 2 * HW;                  // multiplier product width
    localparam int ACC_W      = 2 * AW + 2;              // signed test accumulator

    // Configuration port
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_USE_Z     = 2'd1;

    // Progress along the current line
    localparam logic [1:0] SEEN_START = 2'd0;
    localparam logic [1:0] SEEN_ONE   = 2'd1;
    localparam logic [1:0] SEEN_DIR   = 2'd2;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord pos_x;
        t_coord pos_y;
        t_coord pos_z;
        logic   end_of_line;
    } t_in_item;

    typedef struct packed {
        t_coord out_x;
        t_coord out_y;
        t_coord out_z;
        logic   out_last;
    } t_out_item;

    // Multiplier micro-ops
    typedef enum logic [4:0] {
        MOP_NONE,
        MOP_T2,
        MOP_CX_A, MOP_CX_B, MOP_CY_A, MOP_CY_B, MOP_CZ_A, MOP_CZ_B,
        MOP_C0_LL, MOP_C0_LH, MOP_C0_HH,
        MOP_C1_LL, MOP_C1_LH, MOP_C1_HH,
        MOP_C2_LL, MOP_C2_LH, MOP_C2_HH,
        MOP_TL_LL, MOP_TL_LH, MOP_TL_HL, MOP_TL_HH,
        MOP_S0, MOP_S1, MOP_S2
    } t_mop;

    typedef enum logic [2:0] {
        DST_NONE, DST_THR2, DST_CROSS0, DST_CROSS1, DST_CROSS2, DST_ACC, DST_LENSQ
    } t_dest;

    typedef enum logic [1:0] {
        SH_0, SH_H, SH_H1, SH_2H
    } t_shift;

    typedef struct packed {
        t_dest  dest;
        t_shift shift;
        logic   neg;
    } t_ptag;

    typedef enum logic [1:0] {
        EMIT_NONE, EMIT_CUR, EMIT_ANCHOR
    } t_emit;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECIDE, ST_EMIT_CUR, ST_LENSQ, ST_LDRAIN, ST_TEST, ST_TDRAIN,
        ST_JUDGE, ST_NEWDIR, ST_EMIT_ANC, ST_TAIL
    } t_state;

    typedef struct packed {
        logic  load_in;
        logic  anchor_cur;
        logic  anchor_prev;
        logic  prev_cur;
        logic  set_dir;
        logic  set_d;
        t_mop  mop;
        t_emit emit;
        logic  emit_last;
    } t_cmd;

    typedef struct packed {
        logic eol;
        logic outside;
        logic out_free;
    } t_status;

    // Strip test: threshold squared, cross product, |c|^2 minus thr^2 * |s|^2
    localparam int TEST_LEN  = 20;
    localparam int STEP_BITS = $clog2(TEST_LEN);
    localparam t_mop TEST_SEQ [TEST_LEN] = '{
        MOP_T2,
        MOP_CX_A, MOP_CX_B, MOP_CY_A, MOP_CY_B, MOP_CZ_A, MOP_CZ_B,
        MOP_TL_LL, MOP_TL_LH, MOP_TL_HL, MOP_TL_HH,
        MOP_C0_LL, MOP_C0_LH, MOP_C0_HH,
        MOP_C1_LL, MOP_C1_LH, MOP_C1_HH,
        MOP_C2_LL, MOP_C2_LH, MOP_C2_HH
    };

    // Squared direction length
    localparam int DIR_LEN       = 3;
    localparam int DIR_STEP_BITS = $clog2(DIR_LEN);
    localparam t_mop DIR_SEQ [DIR_LEN] = '{MOP_S0, MOP_S1, MOP_S2};

endpackage
`default_nettype wire

// ===== hw/rtl/rwls_dpath.sv =====
// Datapath of the line simplifier: vertex registers, shared multiplier, accumulators, output register.
`timescale 1ns / 1ps
`default_nettype none
module rwls_dpath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire rwls_pkg::t_in_item                i_in_data,
    input  wire logic                              i_cfg_valid,
    input  wire logic [rwls_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [rwls_pkg::THR_BITS-1:0]     i_cfg_data,
    input  wire rwls_pkg::t_cmd                    i_cmd,
    output rwls_pkg::t_status                      o_status,
    input  wire logic                              i_out_stall,
    output logic                                   o_out_valid,
    output rwls_pkg::t_out_item                    o_out_data
);
    import rwls_pkg::*;

    // Configuration
    logic [THR_BITS-1:0]  r_thr;
    logic                 r_use_z;

    // Vertex state
    t_coord               r_cur    [3];
    logic                 r_eol;
    t_coord               r_anchor [3];
    t_coord               r_prev   [3];
    logic [DIFF_BITS-1:0] r_dir    [3];
    logic [DIFF_BITS-1:0] r_d      [3];
    logic [LW-1:0]        r_lensq;
    logic [THR2_BITS-1:0] r_thr2;
    logic [XW-1:0]        r_cross  [3];
    logic [ACC_W-1:0]     r_acc;

    // Multiplier stage
    logic [PW-1:0]        r_prod;
    t_ptag                r_ptag;
    logic [HW-1:0]        mul_a;
    logic [HW-1:0]        mul_b;
    t_ptag                n_ptag;

    // Output register
    t_out_item            r_out;
    logic                 r_out_valid;

    // Operand views
    logic [HW-1:0]        md [3];
    logic [HW-1:0]        ms [3];
    logic                 sd [3];
    logic                 ss [3];
    logic [HW-1:0]        cl [3];
    logic [HW-1:0]        ch [3];
    logic [AW-1:0]        cmag [3];
    logic [AW-1:0]        thr2_ext;
    logic [AW-1:0]        lensq_ext;
    logic [HW-1:0]        thr_h;

    logic [ACC_W-1:0]     acc_base;
    logic [ACC_W-1:0]     acc_sh;
    logic [ACC_W-1:0]     acc_term;
    logic [XW-1:0]        x_base;
    logic [XW-1:0]        x_term;
    logic [DIFF_BITS-1:0] cur_minus_anchor [3];

    function automatic logic [DIFF_BITS-1:0] diff_of(input t_coord a, input t_coord b);
        logic [DIFF_BITS-1:0] ea;
        logic [DIFF_BITS-1:0] eb;
        ea = {a[COORD_BITS-1], a};
        eb = {b[COORD_BITS-1], b};
        return ea - eb;
    endfunction

    function automatic logic [HW-1:0] mag_diff(input logic [DIFF_BITS-1:0] v);
        logic [DIFF_BITS-1:0] m;
        m = v[DIFF_BITS-1] ? (~v + 1'b1) : v;
        return HW'(m[COORD_BITS-1:0]);
    endfunction

    function automatic logic [AW-1:0] mag_cross(input logic [XW-1:0] v);
        logic [XW-1:0] m;
        m = v[XW-1] ? (~v + 1'b1) : v;
        return AW'(m);
    endfunction

    // Differences from the anchor
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cur_minus_anchor[k] = diff_of(r_cur[k], r_anchor[k]);
        end
    end

    // Magnitudes and halves fed to the multiplier
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            md[k]   = mag_diff(r_d[k]);
            ms[k]   = mag_diff(r_dir[k]);
            sd[k]   = r_d[k][DIFF_BITS-1];
            ss[k]   = r_dir[k][DIFF_BITS-1];
            cmag[k] = mag_cross(r_cross[k]);
            cl[k]   = cmag[k][HW-1:0];
            ch[k]   = HW'(cmag[k][AW-1:HW]);
        end
        thr2_ext  = AW'(r_thr2);
        lensq_ext = AW'(r_lensq);
        thr_h     = HW'(r_thr);
    end

    // Micro-op decode
    always_comb begin
        mul_a        = '0;
        mul_b        = '0;
        n_ptag.dest  = DST_NONE;
        n_ptag.shift = SH_0;
        n_ptag.neg   = 1'b0;
        case (i_cmd.mop)
            MOP_T2: begin
                mul_a = thr_h; mul_b = thr_h; n_ptag.dest = DST_THR2;
            end
            MOP_CX_A: begin
                mul_a = md[1]; mul_b = ms[2]; n_ptag.dest = DST_CROSS0;
                n_ptag.neg = sd[1] ^ ss[2];
            end
            MOP_CX_B: begin
                mul_a = md[2]; mul_b = ms[1]; n_ptag.dest = DST_CROSS0;
                n_ptag.neg = ~(sd[2] ^ ss[1]);
            end
            MOP_CY_A: begin
                mul_a = md[2]; mul_b = ms[0]; n_ptag.dest = DST_CROSS1;
                n_ptag.neg = sd[2] ^ ss[0];
            end
            MOP_CY_B: begin
                mul_a = md[0]; mul_b = ms[2]; n_ptag.dest = DST_CROSS1;
                n_ptag.neg = ~(sd[0] ^ ss[2]);
            end
            MOP_CZ_A: begin
                mul_a = md[0]; mul_b = ms[1]; n_ptag.dest = DST_CROSS2;
                n_ptag.neg = sd[0] ^ ss[1];
            end
            MOP_CZ_B: begin
                mul_a = md[1]; mul_b = ms[0]; n_ptag.dest = DST_CROSS2;
                n_ptag.neg = ~(sd[1] ^ ss[0]);
            end
            MOP_C0_LL: begin
                mul_a = cl[0]; mul_b = cl[0]; n_ptag.dest = DST_ACC;
            end
            MOP_C0_LH: begin
                mul_a = cl[0]; mul_b = ch[0]; n_ptag.dest = DST_ACC; n_ptag.shift = SH_H1;
            end
            MOP_C0_HH: begin
                mul_a = ch[0]; mul_b = ch[0]; n_ptag.dest = DST_ACC; n_ptag.shift = SH_2H;
            end
            MOP_C1_LL: begin
                mul_a = cl[1]; mul_b = cl[1]; n_ptag.dest = DST_ACC;
            end
            MOP_C1_LH: begin
                mul_a = cl[1]; mul_b = ch[1]; n_ptag.dest = DST_ACC; n_ptag.shift = SH_H1;
            end
            MOP_C1_HH: begin
                mul_a = ch[1]; mul_b = ch[1]; n_ptag.dest = DST_ACC; n_ptag.shift = SH_2H;
            end
            MOP_C2_LL: begin
                mul_a = cl[2]; mul_b = cl[2]; n_ptag.dest = DST_ACC;
            end
            MOP_C2_LH: begin
                mul_a = cl[2]; mul_b = ch[2]; n_ptag.dest = DST_ACC; n_ptag.shift = SH_H1;
            end
            MOP_C2_HH: begin
                mul_a = ch[2]; mul_b = ch[2]; n_ptag.dest = DST_ACC; n_ptag.shift = SH_2H;
            end
            MOP_TL_LL: begin
                mul_a = thr2_ext[HW-1:0]; mul_b = lensq_ext[HW-1:0];
                n_ptag.dest = DST_ACC; n_ptag.neg = 1'b1;
            end
            MOP_TL_LH: begin
                mul_a = thr2_ext[HW-1:0]; mul_b = HW'(lensq_ext[AW-1:HW]);
                n_ptag.dest = DST_ACC; n_ptag.neg = 1'b1; n_ptag.shift = SH_H;
            end
            MOP_TL_HL: begin
                mul_a = HW'(thr2_ext[AW-1:HW]); mul_b = lensq_ext[HW-1:0];
                n_ptag.dest = DST_ACC; n_ptag.neg = 1'b1; n_ptag.shift = SH_H;
            end
            MOP_TL_HH: begin
                mul_a = HW'(thr2_ext[AW-1:HW]); mul_b = HW'(lensq_ext[AW-1:HW]);
                n_ptag.dest = DST_ACC; n_ptag.neg = 1'b1; n_ptag.shift = SH_2H;
            end
            MOP_S0: begin
                mul_a = ms[0]; mul_b = ms[0]; n_ptag.dest = DST_LENSQ;
            end
            MOP_S1: begin
                mul_a = ms[1]; mul_b = ms[1]; n_ptag.dest = DST_LENSQ;
            end
            MOP_S2: begin
                mul_a = ms[2]; mul_b = ms[2]; n_ptag.dest = DST_LENSQ;
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // Product alignment for the accumulators
    always_comb begin
        acc_base = ACC_W'(r_prod);
        case (r_ptag.shift)
            SH_0:    acc_sh = acc_base;
            SH_H:    acc_sh = acc_base << HW;
            SH_H1:   acc_sh = acc_base << (HW + 1);
            SH_2H:   acc_sh = acc_base << (2 * HW);
            default: acc_sh = acc_base;
        endcase
        acc_term = r_ptag.neg ? (~acc_sh + 1'b1) : acc_sh;
        x_base   = r_prod[XW-1:0];
        x_term   = r_ptag.neg ? (~x_base + 1'b1) : x_base;
    end

    // Multiplier stage: product registered with its destination tag
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_ptag <= '{dest: DST_NONE, shift: SH_0, neg: 1'b0};
        end else begin
            r_ptag <= n_ptag;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= '0;
            r_use_z <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_thr   <= i_cfg_data;
                CFG_USE_Z:     r_use_z <= i_cfg_data[0];
                default:       r_thr   <= r_thr;
            endcase
        end
    end

    // Vertex registers, direction, differences
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cur[0] <= i_in_data.pos_x;
            r_cur[1] <= i_in_data.pos_y;
            r_cur[2] <= i_in_data.pos_z;
            r_eol    <= i_in_data.end_of_line;
        end
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.anchor_cur) begin
                r_anchor[k] <= r_cur[k];
            end else if (i_cmd.anchor_prev) begin
                r_anchor[k] <= r_prev[k];
            end
            if (i_cmd.prev_cur) begin
                r_prev[k] <= r_cur[k];
            end
        end
        // z drops out of the plane test unless use_z is set
        if (i_cmd.set_dir) begin
            r_dir[0] <= cur_minus_anchor[0];
            r_dir[1] <= cur_minus_anchor[1];
            r_dir[2] <= r_use_z ? cur_minus_anchor[2] : '0;
        end
        if (i_cmd.set_d) begin
            r_d[0] <= cur_minus_anchor[0];
            r_d[1] <= cur_minus_anchor[1];
            r_d[2] <= r_use_z ? cur_minus_anchor[2] : '0;
        end
    end

    // Accumulators
    always_ff @(posedge i_clk) begin
        if (r_ptag.dest == DST_THR2) begin
            r_thr2 <= r_prod[THR2_BITS-1:0];
        end
        if (i_cmd.set_dir) begin
            r_lensq <= '0;
        end else if (r_ptag.dest == DST_LENSQ) begin
            r_lensq <= r_lensq + r_prod[LW-1:0];
        end
        if (i_cmd.set_d) begin
            r_acc <= '0;
            for (int k = 0; k < 3; k++) begin
                r_cross[k] <= '0;
            end
        end else begin
            if (r_ptag.dest == DST_ACC) begin
                r_acc <= r_acc + acc_term;
            end
            if (r_ptag.dest == DST_CROSS0) begin
                r_cross[0] <= r_cross[0] + x_term;
            end
            if (r_ptag.dest == DST_CROSS1) begin
                r_cross[1] <= r_cross[1] + x_term;
            end
            if (r_ptag.dest == DST_CROSS2) begin
                r_cross[2] <= r_cross[2] + x_term;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        case (i_cmd.emit)
            EMIT_CUR: begin
                r_out <= '{out_x: r_cur[0], out_y: r_cur[1], out_z: r_cur[2],
                           out_last: i_cmd.emit_last};
            end
            EMIT_ANCHOR: begin
                r_out <= '{out_x: r_anchor[0], out_y: r_anchor[1], out_z: r_anchor[2],
                           out_last: i_cmd.emit_last};
            end
            default: begin
                r_out <= r_out;
            end
        endcase
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit != EMIT_NONE) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.eol      = r_eol;
    assign o_status.outside  = !r_acc[ACC_W-1] && (r_acc != '0);
    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

    // Clearing never races a pending product into the same register
    a_clr_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.set_d |-> (r_ptag.dest == DST_NONE))
        else $error("test accumulators cleared with a product in flight");
    a_clr_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.set_dir |-> (r_ptag.dest != DST_LENSQ))
        else $error("length cleared with a product in flight");
    // A waiting item is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> (i_cmd.emit == EMIT_NONE))
        else $error("output item overwritten while stalled");

endmodule
`default_nettype wire

// ===== hw/rtl/rwls_ctrl.sv =====
// Controller of the line simplifier: per-vertex sequencer driving the datapath.
`timescale 1ns / 1ps
`default_nettype none
module rwls_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire rwls_pkg::t_status i_status,
    output rwls_pkg::t_cmd         o_cmd
);
    import rwls_pkg::*;

    t_state               r_state;
    t_state               n_state;
    logic [1:0]           r_seen;
    logic [1:0]           n_seen;
    logic [STEP_BITS-1:0] r_step;
    logic [STEP_BITS-1:0] n_step;
    logic                 r_retest;
    logic                 n_retest;
    logic                 r_last;
    logic                 n_last;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_seen   <= SEEN_START;
            r_step   <= '0;
            r_retest <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_seen   <= n_seen;
            r_step   <= n_step;
            r_retest <= n_retest;
            r_last   <= n_last;
        end
    end

    // Next state and commands
    always_comb begin
        n_state  = r_state;
        n_seen   = r_seen;
        n_step   = r_step;
        n_retest = r_retest;
        n_last   = r_last;
        o_cmd    = '{load_in: 1'b0, anchor_cur: 1'b0, anchor_prev: 1'b0, prev_cur: 1'b0,
                     set_dir: 1'b0, set_d: 1'b0, mop: MOP_NONE, emit: EMIT_NONE,
                     emit_last: 1'b0};
        case (r_state)
            ST_IDLE: begin
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_step = '0;
                case (r_seen)
                    SEEN_START: begin
                        o_cmd.anchor_cur = 1'b1;
                        n_last  = i_status.eol;
                        n_seen  = i_status.eol ? SEEN_START : SEEN_ONE;
                        n_state = ST_EMIT_CUR;
                    end
                    SEEN_ONE: begin
                        if (i_status.eol) begin
                            n_last  = 1'b1;
                            n_seen  = SEEN_START;
                            n_state = ST_EMIT_CUR;
                        end else begin
                            o_cmd.prev_cur = 1'b1;
                            o_cmd.set_dir  = 1'b1;
                            n_seen   = SEEN_DIR;
                            n_retest = 1'b0;
                            n_state  = ST_LENSQ;
                        end
                    end
                    default: begin
                        o_cmd.set_d = 1'b1;
                        n_state     = ST_TEST;
                    end
                endcase
            end
            ST_EMIT_CUR: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = EMIT_CUR;
                    o_cmd.emit_last = r_last;
                    n_state         = ST_IDLE;
                end
            end
            // Squared direction length
            ST_LENSQ: begin
                o_cmd.mop = DIR_SEQ[r_step[DIR_STEP_BITS-1:0]];
                if (r_step == STEP_BITS'(DIR_LEN - 1)) begin
                    n_state = ST_LDRAIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_LDRAIN: begin
                n_state = r_retest ? ST_EMIT_ANC : ST_IDLE;
            end
            // Strip test
            ST_TEST: begin
                o_cmd.mop = TEST_SEQ[r_step];
                if (r_step == STEP_BITS'(TEST_LEN - 1)) begin
                    n_state = ST_TDRAIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_TDRAIN: begin
                n_state = ST_JUDGE;
            end
            ST_JUDGE: begin
                if (i_status.outside) begin
                    o_cmd.anchor_prev = 1'b1;
                    n_state = ST_NEWDIR;
                end else begin
                    n_state = ST_TAIL;
                end
            end
            ST_NEWDIR: begin
                o_cmd.set_dir = 1'b1;
                n_step   = '0;
                n_retest = 1'b1;
                n_state  = ST_LENSQ;
            end
            ST_EMIT_ANC: begin
                if (i_status.out_free) begin
                    o_cmd.emit = EMIT_ANCHOR;
                    n_state    = ST_TAIL;
                end
            end
            ST_TAIL: begin
                o_cmd.prev_cur = 1'b1;
                if (i_status.eol) begin
                    n_last  = 1'b1;
                    n_seen  = SEEN_START;
                    n_state = ST_EMIT_CUR;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    a_seen_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seen == SEEN_START) || (r_seen == SEEN_ONE) || (r_seen == SEEN_DIR))
        else $error("line progress out of range");
    a_accept_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ST_DECIDE))
        else $error("accepted item not dispatched");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TEST) |-> (r_step < STEP_BITS'(TEST_LEN)))
        else $error("test step past end of sequence");

endmodule
`default_nettype wire

// ===== hw/rtl/reumann_witkam_line_simplify.sv =====
// Top level of the streaming Reumann-Witkam polyline simplifier.
//
//  channel  direction  handshake            payload
//  in       input      i_in_valid/o_in_stall  i_in_data  (x, y, z, end_of_line)
//  out      output     o_out_valid/i_out_stall o_out_data (x, y, z, out_last)
//  cfg      input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
//  First vertex, or a second one that ends the line: decide and emit, plus output wait.
//  Other second vertices: set the direction and sum its squared length. Later ones: the strip
//  test, run as the 20-step op sequence on one multiplier, then a new direction and the anchor
//  emitted plus output wait when a new anchor is set. A final vertex adds an emit of its output item.
//  Reset is synchronous, active low; threshold and use_z return to zero.
//  A stalled output holds its item; the next vertex is still taken and worked on.
`timescale 1ns / 1ps
`default_nettype none
module reumann_witkam_line_simplify (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire rwls_pkg::t_in_item                i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output rwls_pkg::t_out_item                    o_out_data,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [rwls_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [rwls_pkg::THR_BITS-1:0]     i_cfg_data
);
    import rwls_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Register writes are always taken
    assign o_cfg_ready = 1'b1;

    rwls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rwls_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

// ===== tb/reumann_witkam_line_simplify_tb.sv =====
// Self-checking testbench for the streaming Reumann-Witkam line simplifier.
`timescale 1ns / 1ps
module reumann_witkam_line_simplify_tb;
    import rwls_pkg::*;

    localparam int CYCLE_LIMIT  = 600_000;
    localparam int DRAIN_CYCLES = 40;     // longest vertex plus margin
    localparam int LONG_HOLD    = 400;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 156;
    localparam int PRESSURE_PHASE = 2;

    // Register indexes the block does not decode
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 2'd3;

    typedef logic signed [159:0] t_wide;

    typedef enum logic [1:0] {
        ROW_VERTEX, ROW_THRESHOLD, ROW_USE_Z
    } t_row_kind;

    // One directed row: a vertex, or a register value carried in x
    typedef struct packed {
        t_row_kind   kind;
        logic [23:0] x;
        logic [23:0] y;
        logic [23:0] z;
        logic        eol;
        logic        typed;
        t_out_item   kept;
    } t_row;

    localparam t_out_item NO_KEPT = '0;

    localparam int DIR_ROWS = 27;
    localparam t_row DIRECTED [DIR_ROWS] = '{
        // lone vertices at both corners of the coordinate range
        '{ROW_VERTEX, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 1'b1,
          '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1}},
        '{ROW_VERTEX, 24'h800000, 24'h800000, 24'h800000, 1'b1, 1'b1,
          '{24'h800000, 24'h800000, 24'h800000, 1'b1}},
        // two-vertex line passes straight through
        '{ROW_VERTEX, 24'h000000, 24'h000000, 24'h000000, 1'b0, 1'b1,
          '{24'h000000, 24'h000000, 24'h000000, 1'b0}},
        '{ROW_VERTEX, 24'h800000, 24'h7FFFFF, 24'h800000, 1'b1, 1'b1,
          '{24'h800000, 24'h7FFFFF, 24'h800000, 1'b1}},
        // collinear in the plane, z ignored, zero threshold
        '{ROW_VERTEX, 24'd0, 24'd0, 24'd0, 1'b0, 1'b1, '{24'd0, 24'd0, 24'd0, 1'b0}},
        '{ROW_VERTEX, 24'd10, 24'd10, 24'd5, 1'b0, 1'b0, NO_KEPT},
        '{ROW_VERTEX, 24'd20, 24'd20, 24'hFFFFF9, 1'b1, 1'b0, NO_KEPT},
        // final vertex off the strip: new anchor and final vertex together
        '{ROW_VERTEX, 24'd0, 24'd0, 24'd0, 1'b0, 1'b1, '{24'd0, 24'd0, 24'd0, 1'b0}},
        '{ROW_VERTEX, 24'd10, 24'd0, 24'd0, 1'b0, 1'b0, NO_KEPT},
        '{ROW_VERTEX, 24'd10, 24'd10, 24'd0, 1'b1, 1'b0, NO_KEPT},
        // zero-length direction never leaves the strip
        '{ROW_VERTEX, 24'd5, 24'd5, 24'd5, 1'b0, 1'b1, '{24'd5, 24'd5, 24'd5, 1'b0}},
        '{ROW_VERTEX, 24'd5, 24'd5, 24'd5, 1'b0, 1'b0, NO_KEPT},
        '{ROW_VERTEX, 24'd100, 24'hFFFF9C, 24'd3, 1'b0, 1'b0, NO_KEPT},
        '{ROW_VERTEX, 24'd7, 24'd7, 24'd7, 1'b1, 1'b0, NO_KEPT},
        // widest strip with z, corner to corner
        '{ROW_THRESHOLD, 24'hFFFFFF, 24'd0, 24'd0, 1'b0, 1'b0, NO_KEPT},
        '{ROW_USE_Z, 24'd1, 24'd0, 24'd0, 1'b0, 1'b0, NO_KEPT},
        '{ROW_VERTEX, 24'h800000, 24'h800000, 24'h800000, 1'b0, 1'b1,
          '{24'h800000, 24'h800000, 24'h800000, 1'b0}},
        '{ROW_VERTEX, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0, 1'b0, NO_KEPT},
        '{ROW_VERTEX, 24'h800000, 24'h7FFFFF, 24'h800000, 1'b0, 1'b0, NO_KEPT},
        '{ROW_VERTEX, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b1, 1'b0, NO_KEPT},
        // narrow strip; z switched on after the direction is formed
        '{ROW_THRESHOLD, 24'd2, 24'd0, 24'd0, 1'b0, 1'b0, NO_KEPT},
        '{ROW_USE_Z, 24'd0, 24'd0, 24'd0, 1'b0, 1'b0, NO_KEPT},
        '{ROW_VERTEX, 24'd0, 24'd0, 24'd0, 1'b0, 1'b1, '{24'd0, 24'd0, 24'd0, 1'b0}},
        '{ROW_VERTEX, 24'd100, 24'd0, 24'd0, 1'b0, 1'b0, NO_KEPT},
        '{ROW_USE_Z, 24'd1, 24'd0, 24'd0, 1'b0, 1'b0, NO_KEPT},
        '{ROW_VERTEX, 24'd50, 24'd0, 24'd40, 1'b0, 1'b0, NO_KEPT},
        '{ROW_VERTEX, 24'd200, 24'd0, 24'd0, 1'b1, 1'b0, NO_KEPT}
    };

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    t_in_item                i_in_data;
    logic                    o_out_valid;
    logic                    i_out_stall;
    t_out_item               o_out_data;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index;
    logic [THR_BITS-1:0]     i_cfg_data;

    reumann_witkam_line_simplify dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor state: mirror of the block's line tracking and registers
    t_coord      anchor_v [3];
    t_coord      prev_v [3];
    longint      strip_dir [3];
    t_wide       strip_len2;
    logic [1:0]  line_seen;
    logic [23:0] strip_half_width;
    logic        z_enabled;

    t_out_item kept_vertices [$];
    int        mismatches    = 0;
    int        vertices_sent = 0;
    int        cycle_count   = 0;
    bit        send_idle     = 1'b1;
    bit        recv_idle     = 1'b1;
    bit        hold_long     = 1'b0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_long) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_long = 1'b0;
                i_out_stall <= 1'b0;
            end else if (recv_idle && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Direction from one point to another; z dropped while z is off
    function automatic void form_strip(t_coord from_pt [3], t_coord to_pt [3]);
        longint len2;
        for (int k = 0; k < 3; k++)
            strip_dir[k] = longint'(to_pt[k]) - longint'(from_pt[k]);
        if (!z_enabled)
            strip_dir[2] = 0;
        len2 = strip_dir[0] * strip_dir[0] + strip_dir[1] * strip_dir[1]
             + strip_dir[2] * strip_dir[2];
        strip_len2 = t_wide'(len2);
    endfunction

    // Cross-multiplied strip test, exact in wide arithmetic
    function automatic bit strip_exceeded(t_coord pt [3]);
        longint d [3];
        longint dd;
        longint dot;
        t_wide  dd_w;
        t_wide  dot_w;
        t_wide  thr_w;
        for (int k = 0; k < 3; k++)
            d[k] = longint'(pt[k]) - longint'(anchor_v[k]);
        if (!z_enabled)
            d[2] = 0;
        dd  = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
        dot = d[0] * strip_dir[0] + d[1] * strip_dir[1] + d[2] * strip_dir[2];
        dd_w  = t_wide'(dd);
        dot_w = t_wide'(dot);
        thr_w = t_wide'(strip_half_width);
        return dd_w * strip_len2 > dot_w * dot_w + thr_w * thr_w * strip_len2;
    endfunction

    function automatic t_out_item kept_of(t_coord pt [3], logic last);
        t_out_item r;
        r.out_x    = pt[0];
        r.out_y    = pt[1];
        r.out_z    = pt[2];
        r.out_last = last;
        return r;
    endfunction

    // Advance the line state by one vertex; returns how many vertices it keeps
    function automatic int advance_line(t_in_item v, output t_out_item r0,
                                        output t_out_item r1);
        t_coord p [3];
        int     n;
        p[0] = v.pos_x;
        p[1] = v.pos_y;
        p[2] = v.pos_z;
        n  = 0;
        r0 = NO_KEPT;
        r1 = NO_KEPT;
        case (line_seen)
            SEEN_START: begin
                r0 = kept_of(p, v.end_of_line);
                n = 1;
                anchor_v = p;
                line_seen = v.end_of_line ? SEEN_START : SEEN_ONE;
            end
            SEEN_ONE: begin
                if (v.end_of_line) begin
                    r0 = kept_of(p, 1'b1);
                    n = 1;
                    line_seen = SEEN_START;
                end else begin
                    prev_v = p;
                    form_strip(anchor_v, p);
                    line_seen = SEEN_DIR;
                end
            end
            default: begin
                // outside: previous vertex becomes the anchor and is kept
                if (strip_exceeded(p)) begin
                    anchor_v = prev_v;
                    form_strip(prev_v, p);
                    r0 = kept_of(anchor_v, 1'b0);
                    n = 1;
                end
                prev_v = p;
                if (v.end_of_line) begin
                    if (n == 0)
                        r0 = kept_of(p, 1'b1);
                    else
                        r1 = kept_of(p, 1'b1);
                    n++;
                    line_seen = SEEN_START;
                end
            end
        endcase
        return n;
    endfunction

    // Offer one vertex, wait for it to be taken, then log what it keeps
    task automatic push_vertex(t_in_item v, bit typed, t_out_item kept);
        int        gap;
        int        n;
        t_out_item r0;
        t_out_item r1;
        gap = 0;
        if (send_idle && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 12);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= v;
        do @(posedge i_clk); while (o_in_stall);
        vertices_sent++;
        n = advance_line(v, r0, r1);
        if (typed) begin
            kept_vertices.push_back(kept);
        end else begin
            if (n > 0) kept_vertices.push_back(r0);
            if (n > 1) kept_vertices.push_back(r1);
        end
    endtask

    // Stop offering, let every kept vertex come out and the block go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (kept_vertices.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [THR_BITS-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_THRESHOLD)
            strip_half_width = value;
        else if (idx == CFG_USE_Z)
            z_enabled = value[0];
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int spread(int scale);
        return int'($urandom_range(0, 2 * scale)) - scale;
    endfunction

    // One random polyline: a drifting walk, or pure noise when scale is zero
    task automatic random_line();
        int          len;
        int          scale;
        int          drift [3];
        logic [23:0] pc [3];
        logic [23:0] zdata;
        t_in_item    v;
        case ($urandom_range(0, 9))
            0:       len = 1;
            1:       len = 2;
            default: len = $urandom_range(3, 14);
        endcase
        case ($urandom_range(0, 5))
            0:       scale = 2;
            1:       scale = 16;
            2:       scale = 400;
            3:       scale = 1 << 14;
            4:       scale = 1 << 22;
            default: scale = 0;
        endcase
        for (int a = 0; a < 3; a++) begin
            pc[a] = 24'($urandom);
            drift[a] = (scale == 0) ? 0 : spread(4 * scale);
        end
        for (int k = 0; k < len; k++) begin
            if (k > 0) begin
                for (int a = 0; a < 3; a++)
                    pc[a] = (scale == 0) ? 24'($urandom)
                                         : pc[a] + 24'(drift[a] + spread(scale));
            end
            v.pos_x       = pc[0];
            v.pos_y       = pc[1];
            v.pos_z       = pc[2];
            v.end_of_line = (k == len - 1);
            push_vertex(v, 1'b0, NO_KEPT);
            // now and then flip z handling part way along a line
            if (k < len - 1 && $urandom_range(0, 99) == 0) begin
                settle();
                zdata = 24'($urandom);
                write_reg(CFG_USE_Z, zdata);
            end
        end
    endtask

    // Checker: each kept vertex against the oldest expectation
    task automatic report_field(string name, logic [23:0] want, logic [23:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : kept_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (kept_vertices.size() == 0) begin
                mismatches++;
                $display("%0t: kept vertex expected none actual %h", $time, o_out_data);
            end else begin
                want = kept_vertices.pop_front();
                report_field("out_x", want.out_x, o_out_data.out_x);
                report_field("out_y", want.out_y, o_out_data.out_y);
                report_field("out_z", want.out_z, o_out_data.out_z);
                report_field("out_last", 24'(want.out_last), 24'(o_out_data.out_last));
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        t_in_item    v;
        logic [23:0] thr;
        logic [23:0] zdata;
        int          target;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        strip_half_width = '0;
        z_enabled   = 1'b0;
        line_seen   = SEEN_START;
        strip_len2  = '0;
        for (int k = 0; k < 3; k++) begin
            anchor_v[k]  = '0;
            prev_v[k]    = '0;
            strip_dir[k] = 0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (DIRECTED[i]) begin
            case (DIRECTED[i].kind)
                ROW_THRESHOLD: begin
                    settle();
                    write_reg(CFG_THRESHOLD, DIRECTED[i].x);
                end
                ROW_USE_Z: begin
                    settle();
                    write_reg(CFG_USE_Z, DIRECTED[i].x);
                end
                default: begin
                    v.pos_x       = DIRECTED[i].x;
                    v.pos_y       = DIRECTED[i].y;
                    v.pos_z       = DIRECTED[i].z;
                    v.end_of_line = DIRECTED[i].eol;
                    push_vertex(v, DIRECTED[i].typed, DIRECTED[i].kept);
                end
            endcase
        end

        // random phases, each under its own register settings
        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            case ($urandom_range(0, 4))
                0:       thr = 24'd0;
                1:       thr = 24'($urandom_range(1, 8));
                2:       thr = 24'($urandom_range(9, 500));
                3:       thr = 24'hFFFFFF;
                default: thr = 24'($urandom);
            endcase
            zdata = 24'($urandom);
            if (phase == 0) begin
                thr = 24'd0;
                zdata[0] = 1'b0;
            end else if (phase == 1) begin
                thr = 24'hFFFFFF;
                zdata[0] = 1'b1;
            end
            write_reg(CFG_THRESHOLD, thr);
            write_reg(CFG_USE_Z, zdata);
            if (phase == 3) begin
                write_reg(CFG_SPARE_A, 24'($urandom));
                write_reg(CFG_SPARE_B, 24'($urandom));
            end
            recv_idle = (phase != PHASES - 1);
            send_idle = (phase != PHASES - 1) && (phase != PRESSURE_PHASE);
            // receiver holds off while the sender keeps offering
            if (phase == PRESSURE_PHASE)
                hold_long = 1'b1;
            target = vertices_sent + PHASE_ITEMS;
            while (vertices_sent < target)
                random_line();
        end

        settle();
        if (mismatches == 0 && kept_vertices.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
